[hdl/ssrc_pkg.sv]
// Shared widths, codes, reset values and control structs of the stereo rate converter.
package ssrc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 18;
    localparam int ACC_W    = 20;
    localparam int PHASE_W  = 36;
    localparam int INC_W    = 35;
    localparam int QUO_W    = 34;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 34;
    localparam int DIFF_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_REPEAT = 2'd1;
    localparam logic [1:0] MODE_LINEAR = 2'd2;
    localparam logic [1:0] MODE_RST    = MODE_REPEAT;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE = 2'd2;

    localparam logic [RATE_W-1:0] IN_RATE_RST  = 18'd32000;
    localparam logic [RATE_W-1:0] OUT_RATE_RST = 18'd48000;
    localparam logic [INC_W-1:0]  INC_RST =
        INC_W'((64'(IN_RATE_RST) << FRAC_W) / 64'(OUT_RATE_RST));
    localparam logic [INC_W-1:0]  INC_MAX = '1;
    localparam logic [ACC_W-1:0]  ACC_MAX = '1;
    localparam logic [PHASE_W-1:0] PHASE_ONE = 36'h0_0001_0000;

    typedef enum logic {
        SEL_SAMPLE,
        SEL_LERP
    } out_sel_t;

    typedef struct packed {
        logic     cfg_ready;
        logic     in_ready;
        logic     in_load;
        logic     acc_add;
        logic     prime;
        logic     acc_sub;
        logic     mul;
        logic     lin_finish;
        logic     emit;
        out_sel_t emit_sel;
        logic     emit_last;
        logic     div_load;
        logic     div_step;
        logic     div_finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       acc_ge_rate;
        logic       phase_lt_one;
        logic       prev_valid;
        logic       out_free;
        logic       div_last;
    } status_t;

endpackage

[hdl/stereo_sample_rate_converter_core.sv]
// Top level of the stereo sample rate converter: passthrough, repeat and linear modes.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  s_tdata: left_in, right_in
//  m_*      out        m_tvalid / m_tready  m_tdata: left_out, right_out; m_tlast: last
//  cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Passthrough: idle, then an emit state. Repeat: a check and an emit state per result.
// Linear: a check and an emit state per result, then a finish state; priming is idle alone.
// A write to either rate runs a radix-2 divider with the input closed.
// Reset restores the default rates and increment at once, no clearing pass.
// A stalled output holds the controller in its emit state; one finished result
// waits in the output register while the next input beat is taken.
module stereo_sample_rate_converter_core
#(
    parameter int MAX_BURST = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] left_in, [31:16] right_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] left_out, [31:16] right_out
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ssrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssrc_pkg::RATE_W-1:0]    cfg_data
);

    ssrc_pkg::cmd_t    cmd;
    ssrc_pkg::status_t status;
    logic signed [ssrc_pkg::SAMPLE_W-1:0] left_out;
    logic signed [ssrc_pkg::SAMPLE_W-1:0] right_out;

    ssrc_ctrl
    #(
        .MAX_BURST (MAX_BURST)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .status    (status),
        .cmd       (cmd)
    );

    ssrc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .left_in   (s_tdata[15:0]),
        .right_in  (s_tdata[31:16]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .left_out  (left_out),
        .right_out (right_out),
        .last_out  (m_tlast)
    );

    assign s_tready  = cmd.in_ready;
    assign cfg_ready = cmd.cfg_ready;
    assign m_tdata   = {right_out, left_out};

endmodule

[hdl/ssrc_div.sv]
// Restoring divider, one quotient bit per cycle while step is high, for the phase increment.
module ssrc_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic                       step,
    input  logic [ssrc_pkg::QUO_W-1:0]  dividend,
    input  logic [ssrc_pkg::RATE_W-1:0] divisor,
    output logic [ssrc_pkg::QUO_W-1:0]  quotient,
    output logic                       last
);

    localparam int CNT_W = $clog2(ssrc_pkg::QUO_W + 1);

    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                cnt_next;
    logic [ssrc_pkg::RATE_W-1:0]     rem_reg;
    logic [ssrc_pkg::RATE_W-1:0]     rem_next;
    logic [ssrc_pkg::QUO_W-1:0]      quo_reg;
    logic [ssrc_pkg::QUO_W-1:0]      quo_next;
    logic [ssrc_pkg::RATE_W:0]       rem_shift;
    logic                            fits;

    assign rem_shift = {rem_reg, quo_reg[ssrc_pkg::QUO_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            cnt_next = CNT_W'(ssrc_pkg::QUO_W);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (step)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (fits)
            begin
                rem_next = ssrc_pkg::RATE_W'(rem_shift - {1'b0, divisor});
            end
            else
            begin
                rem_next = rem_shift[ssrc_pkg::RATE_W-1:0];
            end
            quo_next = {quo_reg[ssrc_pkg::QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign last     = cnt_reg == CNT_W'(1);

endmodule

[hdl/ssrc_datapath.sv]
// Datapath: configuration, accumulator, phase, interpolation and output register.
module ssrc_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ssrc_pkg::cmd_t                 cmd,
    output ssrc_pkg::status_t              status,
    input  logic signed [ssrc_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [ssrc_pkg::SAMPLE_W-1:0] right_in,
    input  logic                           cfg_valid,
    input  logic [ssrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssrc_pkg::RATE_W-1:0]    cfg_data,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic signed [ssrc_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [ssrc_pkg::SAMPLE_W-1:0] right_out,
    output logic                           last_out
);

    logic [1:0]                            mode_reg;
    logic [ssrc_pkg::RATE_W-1:0]           in_rate_reg;
    logic [ssrc_pkg::RATE_W-1:0]           out_rate_reg;
    logic [ssrc_pkg::INC_W-1:0]            inc_reg;
    logic [ssrc_pkg::ACC_W-1:0]            acc_reg;
    logic [ssrc_pkg::PHASE_W-1:0]          phase_reg;
    logic signed [ssrc_pkg::SAMPLE_W-1:0]  left_reg;
    logic signed [ssrc_pkg::SAMPLE_W-1:0]  right_reg;
    logic signed [ssrc_pkg::SAMPLE_W-1:0]  prev_left_reg;
    logic signed [ssrc_pkg::SAMPLE_W-1:0]  prev_right_reg;
    logic                                  prev_valid_reg;
    logic [ssrc_pkg::SAMPLE_W-1:0]         prod_left_reg;
    logic [ssrc_pkg::SAMPLE_W-1:0]         prod_right_reg;
    logic                                  m_valid_reg;
    logic [ssrc_pkg::SAMPLE_W-1:0]         out_left_reg;
    logic [ssrc_pkg::SAMPLE_W-1:0]         out_right_reg;
    logic                                  out_last_reg;

    logic                                  cfg_we;
    logic [ssrc_pkg::ACC_W:0]              acc_sum;
    logic [ssrc_pkg::ACC_W-1:0]            acc_sat;
    logic signed [ssrc_pkg::DIFF_W-1:0]    diff_left;
    logic signed [ssrc_pkg::DIFF_W-1:0]    diff_right;
    logic signed [ssrc_pkg::DIFF_W-1:0]    frac_s;
    logic signed [ssrc_pkg::PROD_W-1:0]    prod_left;
    logic signed [ssrc_pkg::PROD_W-1:0]    prod_right;
    logic [ssrc_pkg::SAMPLE_W-1:0]         lerp_left;
    logic [ssrc_pkg::SAMPLE_W-1:0]         lerp_right;
    logic [ssrc_pkg::QUO_W-1:0]            quotient;
    logic                                  div_last;
    logic                                  out_load;

    assign cfg_we = cfg_valid && cmd.cfg_ready;

    assign acc_sum = {1'b0, acc_reg} + (ssrc_pkg::ACC_W + 1)'(out_rate_reg);
    assign acc_sat = acc_sum[ssrc_pkg::ACC_W] ? ssrc_pkg::ACC_MAX
                                              : acc_sum[ssrc_pkg::ACC_W-1:0];

    assign diff_left  = {left_reg[ssrc_pkg::SAMPLE_W-1], left_reg}
                      - {prev_left_reg[ssrc_pkg::SAMPLE_W-1], prev_left_reg};
    assign diff_right = {right_reg[ssrc_pkg::SAMPLE_W-1], right_reg}
                      - {prev_right_reg[ssrc_pkg::SAMPLE_W-1], prev_right_reg};
    assign frac_s     = {1'b0, phase_reg[ssrc_pkg::FRAC_W-1:0]};
    assign prod_left  = ssrc_pkg::PROD_W'(diff_left) * ssrc_pkg::PROD_W'(frac_s);
    assign prod_right = ssrc_pkg::PROD_W'(diff_right) * ssrc_pkg::PROD_W'(frac_s);

    assign lerp_left  = prev_left_reg + prod_left_reg;
    assign lerp_right = prev_right_reg + prod_right_reg;

    assign out_load = cmd.emit && status.out_free;

    ssrc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend ({in_rate_reg, ssrc_pkg::FRAC_W'(0)}),
        .divisor  (out_rate_reg),
        .quotient (quotient),
        .last     (div_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ssrc_pkg::MODE_RST;
            in_rate_reg    <= ssrc_pkg::IN_RATE_RST;
            out_rate_reg   <= ssrc_pkg::OUT_RATE_RST;
            inc_reg        <= ssrc_pkg::INC_RST;
            acc_reg        <= '0;
            phase_reg      <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            prev_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ssrc_pkg::CFG_MODE:
                    begin
                        mode_reg       <= (cfg_data[1:0] > ssrc_pkg::MODE_LINEAR)
                                          ? ssrc_pkg::MODE_PASS : cfg_data[1:0];
                        acc_reg        <= '0;
                        phase_reg      <= '0;
                        prev_valid_reg <= 1'b0;
                    end
                    ssrc_pkg::CFG_IN_RATE:  in_rate_reg  <= cfg_data;
                    ssrc_pkg::CFG_OUT_RATE: out_rate_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.div_finish)
            begin
                inc_reg <= (out_rate_reg == '0) ? ssrc_pkg::INC_MAX
                                                : ssrc_pkg::INC_W'(quotient);
            end
            if (cmd.acc_add)
            begin
                acc_reg <= acc_sat;
            end
            else if (cmd.acc_sub)
            begin
                acc_reg <= acc_reg - ssrc_pkg::ACC_W'(in_rate_reg);
            end
            if (cmd.prime)
            begin
                prev_left_reg  <= left_in;
                prev_right_reg <= right_in;
                prev_valid_reg <= 1'b1;
            end
            else if (cmd.lin_finish)
            begin
                prev_left_reg  <= left_reg;
                prev_right_reg <= right_reg;
            end
            if (cmd.mul)
            begin
                phase_reg <= phase_reg + ssrc_pkg::PHASE_W'(inc_reg);
            end
            else if (cmd.lin_finish)
            begin
                phase_reg <= status.phase_lt_one ? '0 : phase_reg - ssrc_pkg::PHASE_ONE;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            left_reg  <= left_in;
            right_reg <= right_in;
        end
        if (cmd.mul)
        begin
            prod_left_reg  <= prod_left[ssrc_pkg::FRAC_W +: ssrc_pkg::SAMPLE_W];
            prod_right_reg <= prod_right[ssrc_pkg::FRAC_W +: ssrc_pkg::SAMPLE_W];
        end
        if (out_load)
        begin
            out_last_reg <= cmd.emit_last;
            if (cmd.emit_sel == ssrc_pkg::SEL_LERP)
            begin
                out_left_reg  <= lerp_left;
                out_right_reg <= lerp_right;
            end
            else
            begin
                out_left_reg  <= left_reg;
                out_right_reg <= right_reg;
            end
        end
    end

    assign status.mode         = mode_reg;
    assign status.acc_ge_rate  = acc_reg >= ssrc_pkg::ACC_W'(in_rate_reg);
    assign status.phase_lt_one = phase_reg < ssrc_pkg::PHASE_ONE;
    assign status.prev_valid   = prev_valid_reg;
    assign status.out_free     = !m_valid_reg || m_tready;
    assign status.div_last     = div_last;

    assign m_tvalid  = m_valid_reg;
    assign left_out  = out_left_reg;
    assign right_out = out_right_reg;
    assign last_out  = out_last_reg;

endmodule

[hdl/ssrc_ctrl.sv]
// Controller: sequences accept, bursts, interpolation steps and the increment division.
module ssrc_ctrl
#(
    parameter int MAX_BURST = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           cfg_valid,
    input  logic [ssrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  ssrc_pkg::status_t              status,
    output ssrc_pkg::cmd_t                 cmd
);

    localparam int CNT_W = $clog2(MAX_BURST + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PEMIT,
        ST_RCHK,
        ST_REMIT,
        ST_LCHK,
        ST_LEMIT,
        ST_LFIN,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_END
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic             n_lt_max;
    logic             rate_write;

    assign n_lt_max   = n_reg < CNT_W'(MAX_BURST);
    assign rate_write = (cfg_index == ssrc_pkg::CFG_IN_RATE)
                     || (cfg_index == ssrc_pkg::CFG_OUT_RATE);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.cfg_ready = 1'b1;
                cmd.in_ready  = !cfg_valid;
                if (cfg_valid)
                begin
                    if (rate_write)
                    begin
                        state_next = ST_DIV_LOAD;
                    end
                end
                else if (s_tvalid)
                begin
                    cmd.in_load = 1'b1;
                    n_next      = '0;
                    case (status.mode)
                        ssrc_pkg::MODE_REPEAT:
                        begin
                            cmd.acc_add = 1'b1;
                            state_next  = ST_RCHK;
                        end
                        ssrc_pkg::MODE_LINEAR:
                        begin
                            if (status.prev_valid)
                            begin
                                state_next = ST_LCHK;
                            end
                            else
                            begin
                                cmd.prime = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_PEMIT;
                        end
                    endcase
                end
            end
            ST_PEMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = ssrc_pkg::SEL_SAMPLE;
                cmd.emit_last = 1'b1;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RCHK:
            begin
                if (status.acc_ge_rate && n_lt_max)
                begin
                    cmd.acc_sub = 1'b1;
                    n_next      = n_reg + CNT_W'(1);
                    state_next  = ST_REMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = ssrc_pkg::SEL_SAMPLE;
                cmd.emit_last = !(status.acc_ge_rate && n_lt_max);
                if (status.out_free)
                begin
                    state_next = cmd.emit_last ? ST_IDLE : ST_RCHK;
                end
            end
            ST_LCHK:
            begin
                if (status.phase_lt_one && n_lt_max)
                begin
                    cmd.mul    = 1'b1;
                    n_next     = n_reg + CNT_W'(1);
                    state_next = ST_LEMIT;
                end
                else
                begin
                    state_next = ST_LFIN;
                end
            end
            ST_LEMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_sel  = ssrc_pkg::SEL_LERP;
                cmd.emit_last = !(status.phase_lt_one && n_lt_max);
                if (status.out_free)
                begin
                    state_next = cmd.emit_last ? ST_LFIN : ST_LCHK;
                end
            end
            ST_LFIN:
            begin
                cmd.lin_finish = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END:
            begin
                cmd.div_finish = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

`ifndef SYNTHESIS
    a_burst_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(MAX_BURST))
        else $error("burst count beyond cap");

    a_rate_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && cfg_valid && rate_write) |=> state_reg == ST_DIV_LOAD)
        else $error("rate write did not start division");

    a_lerp_primed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LCHK || state_reg == ST_LEMIT) |-> status.prev_valid)
        else $error("interpolation without previous sample");

    a_last_ends_linear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEMIT && status.out_free && cmd.emit_last)
        |=> state_reg == ST_LFIN)
        else $error("linear burst did not end after last beat");
`endif

endmodule
